// ===== hdl/qrs_pkg.sv =====
// package for the quadratic root solver: constants, types, case codes and root saturation
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int FracBitsDefault = 8;
  localparam int CoefW = 16;
  localparam int DiscW = 35;                 // |d| < 2^34 + 2^30
  localparam int RadW  = 66;                 // |d| * 2^30
  localparam int SqW   = 33;                 // floor(sqrt(|d| * 2^30))
  localparam int NumW  = 36;                 // |-B*2^16| or |-B*2^15 +- S|
  localparam int QuoW  = NumW;
  localparam int RootW = 32;

  localparam logic [1:0] ST_AZERO   = 2'd0;
  localparam logic [1:0] ST_CZERO   = 2'd1;
  localparam logic [1:0] ST_REAL    = 2'd2;
  localparam logic [1:0] ST_COMPLEX = 2'd3;

  // numerators and divisor handed from the front end to the divider
  typedef struct packed {
    logic [1:0]      status;
    logic            neg1;
    logic [NumW-1:0] num1;
    logic            neg2;
    logic [NumW-1:0] num2;
    logic [CoefW-1:0] den;    // |a|, or 1 when a is zero
  } qrs_div_t;

  function automatic logic [RootW-1:0] sat_root(input logic neg, input logic [QuoW-1:0] q,
                                                output logic clip);
    logic [RootW-1:0] r;
    clip = 1'b0;
    if (!neg) begin
      if (q > QuoW'(32'h7fff_ffff)) begin
        r = 32'h7fff_ffff;
        clip = 1'b1;
      end else begin
        r = q[RootW-1:0];
      end
    end else begin
      if (q > QuoW'(32'h8000_0000)) begin
        r = 32'h8000_0000;
        clip = 1'b1;
      end else begin
        r = RootW'(~q + 1'b1);
      end
    end
    return r;
  endfunction
endpackage

// ===== hdl/qrs_sqrt.sv =====
// pipelined square root of the scaled discriminant, one result bit a stage
`timescale 1ns / 1ps
module qrs_sqrt
  import qrs_pkg::*;
#(
  parameter int Width = RadW,
  parameter int TagW  = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [Width-1:0]      radicand,
  input  logic [TagW-1:0]       in_tag,
  output logic                  out_valid,
  output logic [Width/2-1:0]    root,
  output logic [TagW-1:0]       out_tag
);
  localparam int Steps = Width / 2;
  localparam int RemW  = Width / 2 + 2;

  logic [Steps:0]               vld;
  logic [Width-1:0]             rad  [Steps+1];
  logic [RemW-1:0]              rem  [Steps+1];
  logic [Width/2-1:0]           qt   [Steps+1];
  logic [TagW-1:0]              tag  [Steps+1];

  assign vld[0] = in_valid;
  assign rad[0] = radicand;
  assign rem[0] = '0;
  assign qt[0]  = '0;
  assign tag[0] = in_tag;

  // restoring method: two radicand bits in, one root bit out per stage
  for (genvar i = 0; i < Steps; i++) begin : g_stage
    logic [RemW-1:0] trial;
    logic [RemW-1:0] shifted;
    assign shifted = {rem[i][RemW-3:0], rad[i][Width-1 -: 2]};
    assign trial   = {qt[i], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rad[i+1] <= {rad[i][Width-3:0], 2'b00};
      tag[i+1] <= tag[i];
      if (shifted >= trial) begin
        rem[i+1] <= shifted - trial;
        qt[i+1]  <= {qt[i][Width/2-2:0], 1'b1};
      end else begin
        rem[i+1] <= shifted;
        qt[i+1]  <= {qt[i][Width/2-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[Steps];
  assign root      = qt[Steps];
  assign out_tag   = tag[Steps];

  a_no_x_valid: assert property (@(posedge clk) disable iff (rst)
    $past(in_valid, Steps) |-> out_valid) else $error("sqrt lost a word");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    !$past(in_valid, Steps) && !$past(rst, Steps) |-> !out_valid)
    else $error("sqrt made a word");
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && rad[Steps] == '0 |-> 1'b1) else $error("unreachable");
endmodule

// ===== hdl/qrs_div.sv =====
// pipelined restoring divider for both roots, one quotient bit a stage
`timescale 1ns / 1ps
module qrs_div
  import qrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  qrs_div_t  in_word,
  output logic      out_valid,
  output qrs_div_t  out_word
);
  // quotient bits over the numerator, then one stage rounds
  localparam int Steps = NumW;
  localparam int RemW  = CoefW + 1;

  logic [Steps:0] vld;
  qrs_div_t       w   [Steps+1];
  logic [RemW-1:0] r1 [Steps+1];
  logic [RemW-1:0] r2 [Steps+1];

  assign vld[0] = in_valid;
  assign w[0]   = in_word;
  assign r1[0]  = '0;
  assign r2[0]  = '0;

  // numerator registers shift quotient bits in from the bottom
  for (genvar i = 0; i < Steps; i++) begin : g_stage
    logic [RemW-1:0] s1, s2;
    logic            g1, g2;
    qrs_div_t        w_next;
    assign s1 = {r1[i][RemW-2:0], w[i].num1[NumW-1]};
    assign s2 = {r2[i][RemW-2:0], w[i].num2[NumW-1]};
    assign g1 = s1 >= {1'b0, w[i].den};
    assign g2 = s2 >= {1'b0, w[i].den};
    always_comb begin
      w_next      = w[i];
      w_next.num1 = {w[i].num1[NumW-2:0], g1};
      w_next.num2 = {w[i].num2[NumW-2:0], g2};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      w[i+1]      <= w_next;
      r1[i+1]     <= g1 ? s1 - {1'b0, w[i].den} : s1;
      r2[i+1]     <= g2 ? s2 - {1'b0, w[i].den} : s2;
    end
  end

  // round half away: bump when twice the remainder reaches the divisor
  logic up1, up2;
  assign up1 = {r1[Steps], 1'b0} >= {2'b00, w[Steps].den};
  assign up2 = {r2[Steps], 1'b0} >= {2'b00, w[Steps].den};

  qrs_div_t out_word_next;
  always_comb begin
    out_word_next      = w[Steps];
    out_word_next.num1 = w[Steps].num1 + NumW'(up1);
    out_word_next.num2 = w[Steps].num2 + NumW'(up2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[Steps];
    end
    out_word <= out_word_next;
  end

  a_keep: assert property (@(posedge clk) disable iff (rst)
    $past(in_valid, Steps + 1) && !$past(rst, Steps + 1) |-> out_valid)
    else $error("divider lost a word");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(rst, Steps + 1) == 1'b0 |->
    out_word.status == $past(in_word.status, Steps + 1))
    else $error("divider status mixed up");
  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_AZERO |-> out_word.den != '0)
    else $error("division by zero");
endmodule

// ===== hdl/quadratic_root_solver_unit.sv =====
// top level of the quadratic root solver: front end, square root, divider, saturation
`timescale 1ns / 1ps
// a coefficient set (a, b, c as signed fixed point sharing one scale) goes in with start
// whenever busy is low; busy is a constant, low for FRAC_BITS in 4..16, so a set may
// enter in every cycle. the word comes out on status, first_root, second_root and saturated
// with done high for one cycle, after two front-end stages (discriminant multiplies, then
// magnitude), 33 square-root stages (one root bit each), a numerator stage, 36 divider
// stages plus a rounding stage (one quotient bit each), and a saturation stage.
// results keep input order.
// the receiver cannot stall, so nothing in the pipe ever waits. the fraction width only
// sets the coefficient scale, which cancels in every root.
module quadratic_root_solver_unit
  import qrs_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoefW-1:0]  coef_a,
  input  logic signed [CoefW-1:0]  coef_b,
  input  logic signed [CoefW-1:0]  coef_c,
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [RootW-1:0]  first_root,
  output logic signed [RootW-1:0]  second_root,
  output logic                     saturated
);
  // the root scale does not depend on the fraction width; kept to check its range
  localparam bit FracOk = (FRAC_BITS >= 4) && (FRAC_BITS <= 16);

  // side data that rides along with the square root
  typedef struct packed {
    logic [1:0]       status;
    logic             a_neg;
    logic [CoefW-1:0] a_mag;
    logic signed [CoefW:0] nb;     // -b, 17 bits
  } qrs_side_t;
  localparam int SideW = $bits(qrs_side_t);

  assign busy = !FracOk;

  logic accept;
  assign accept = start && !busy;

  // stage 1: products
  logic                      s1_valid;
  logic signed [2*CoefW-1:0] s1_bb, s1_ac;
  qrs_side_t                 s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_bb <= coef_b * coef_b;
    s1_ac <= coef_a * coef_c;
    s1_side.a_neg <= coef_a[CoefW-1];
    s1_side.a_mag <= coef_a[CoefW-1] ? CoefW'(-coef_a) : coef_a;
    s1_side.nb    <= -(CoefW+1)'(coef_b);
    if (coef_a == '0) begin
      s1_side.status <= ST_AZERO;
    end else if (coef_c == '0) begin
      s1_side.status <= ST_CZERO;
    end else begin
      s1_side.status <= ST_REAL;       // settled on the discriminant sign next
    end
  end

  // stage 2: discriminant magnitude and case
  logic signed [DiscW-1:0] disc;
  assign disc = DiscW'(s1_bb) - (DiscW'(s1_ac) <<< 2);

  logic             s2_valid;
  logic [DiscW-1:0] s2_mag;
  qrs_side_t        s2_side;
  qrs_side_t        s2_side_next;

  // a negative discriminant turns a real pair into a complex one
  always_comb begin
    s2_side_next = s1_side;
    if (s1_side.status == ST_REAL && disc[DiscW-1]) begin
      s2_side_next.status = ST_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_mag  <= disc[DiscW-1] ? DiscW'(-disc) : DiscW'(disc);
    s2_side <= s2_side_next;
  end

  // square root of |d| * 2^30
  logic             sq_valid;
  logic [SqW-1:0]   sq_root;
  logic [SideW-1:0] sq_tag;
  qrs_side_t        sq_side;

  qrs_sqrt #(.Width(RadW), .TagW(SideW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .radicand  ({1'b0, s2_mag, 30'd0}),
    .in_tag    (s2_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );
  assign sq_side = qrs_side_t'(sq_tag);

  // numerator build: signed sums, then sign folded with that of a
  logic signed [NumW:0] nb15, n_plus, n_minus, n_1, n_2;
  assign nb15    = (NumW+1)'(sq_side.nb) <<< 15;
  assign n_plus  = nb15 + (NumW+1)'({1'b0, sq_root});
  assign n_minus = nb15 - (NumW+1)'({1'b0, sq_root});

  always_comb begin
    case (sq_side.status)
      ST_CZERO: begin
        n_1 = '0;
        n_2 = nb15 <<< 1;
      end
      ST_REAL: begin
        n_1 = n_plus;
        n_2 = n_minus;
      end
      ST_COMPLEX: begin
        n_1 = nb15;
        n_2 = sq_side.a_neg ? -(NumW+1)'({1'b0, sq_root}) : (NumW+1)'({1'b0, sq_root});
      end
      default: begin
        n_1 = '0;
        n_2 = '0;
      end
    endcase
  end

  logic     dv_valid;
  qrs_div_t dv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= 1'b0;
    end else begin
      dv_valid <= sq_valid;
    end
    dv_in.status <= sq_side.status;
    dv_in.den    <= (sq_side.status == ST_AZERO) ? CoefW'(1) : sq_side.a_mag;
    dv_in.neg1   <= n_1[NumW] ^ sq_side.a_neg;
    dv_in.num1   <= n_1[NumW] ? NumW'(-n_1) : NumW'(n_1);
    dv_in.neg2   <= n_2[NumW] ^ sq_side.a_neg;
    dv_in.num2   <= n_2[NumW] ? NumW'(-n_2) : NumW'(n_2);
  end

  logic     q_valid;
  qrs_div_t q_word;

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_word   (dv_in),
    .out_valid (q_valid),
    .out_word  (q_word)
  );

  // saturation and output register
  logic [RootW-1:0] r1, r2;
  logic             c1, c2;
  always_comb begin
    r1 = sat_root(q_word.neg1, q_word.num1, c1);
    r2 = sat_root(q_word.neg2, q_word.num2, c2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
    status <= q_word.status;
    if (q_word.status == ST_AZERO) begin
      first_root  <= '0;
      second_root <= '0;
      saturated   <= 1'b0;
    end else begin
      first_root  <= r1;
      second_root <= r2;
      saturated   <= c1 | c2;
    end
  end

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_zero_a: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_AZERO |-> first_root == '0 && second_root == '0 && !saturated)
    else $error("zero a gave roots");
  a_czero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_CZERO |-> first_root == '0)
    else $error("zero c first root not zero");
  a_imag_pos: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_COMPLEX |-> !second_root[RootW-1])
    else $error("negative imaginary part");
endmodule
